### src/rnlp_pkg.sv
// Shared types, character codes and helpers for the RESP number line parser.
package rnlp_pkg;

  // Line kind, chosen by the type byte
  typedef enum logic [1:0] {
    KIND_INT   = 2'd0,
    KIND_BULK  = 2'd1,
    KIND_ARRAY = 2'd2,
    KIND_OTHER = 2'd3
  } kind_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  // One input byte of a header line
  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } item_t;

  // One parsed line
  typedef struct packed {
    logic [63:0] number_value;
    kind_t       line_kind;
    status_t     parse_status;
  } result_t;

  // Character codes
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Digit limits for length lines
  localparam logic [4:0] BULK_MAX_DIGITS  = 5'd9;
  localparam logic [4:0] ARRAY_MAX_DIGITS = 5'd10;
  localparam logic [4:0] DIGIT_COUNT_MAX  = 5'd31;

  // Integer range limits
  localparam logic [63:0] TWO_POW_63    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] PRE_MUL_MAX   = TWO_POW_63 / 64'd10;
  localparam logic [63:0] ARRAY_LEN_MAX = 64'h0000_0000_FFFF_FFFF;

  // Null pattern tracking ("-1" CR LF after the type byte)
  localparam logic [2:0] NPM_START  = 3'd1;
  localparam logic [2:0] NPM_TAIL   = 3'd4;
  localparam logic [2:0] NPM_END    = 3'd5;
  localparam logic [2:0] NPM_BROKEN = 3'd7;

  // Configuration port
  localparam int unsigned   ADDR_W          = 3;
  localparam logic          REG_BULK_LIMIT  = 1'b0;
  localparam int unsigned   LIMIT_W         = 30;
  localparam logic [LIMIT_W-1:0] BULK_LIMIT_RESET = 30'd536870912;

  // Expected byte at each position of the null pattern
  function automatic logic [7:0] null_tail(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd1:    ch = CH_MINUS;
      3'd2:    ch = CH_ONE;
      3'd3:    ch = CH_CR;
      3'd4:    ch = CH_LF;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Map a type byte to its line kind
  function automatic kind_t kind_of(input logic [7:0] ch);
    kind_t k;
    unique case (ch)
      CH_COLON:  k = KIND_INT;
      CH_DOLLAR: k = KIND_BULK;
      CH_STAR:   k = KIND_ARRAY;
      default:   k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

### src/rnlp_in_stage.sv
// Input register stage: captures one byte transfer and holds it until the core takes it.
module rnlp_in_stage
  import rnlp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  s_valid,
  output logic  s_ready,
  input  item_t s_item,
  output logic  valid,
  output item_t item,
  input  logic  core_ready
);

  // Take a new transfer when empty or when the held one moves on
  assign s_ready = !valid || core_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_ready) begin
      valid <= s_valid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item <= s_item;
    end
  end

endmodule

### src/rnlp_core.sv
// Line parser core: per-line state, digit accumulation and the result register.
module rnlp_core
  import rnlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  item_t              in_item,
  output logic               core_ready,
  input  logic [LIMIT_W-1:0] bulk_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output result_t            result
);

  // Line state
  logic        at_line_start, at_line_start_next;
  kind_t       mode, mode_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  logic [63:0] accumulator, accumulator_next;
  logic [4:0]  digit_count, digit_count_next;
  logic        negative_seen, negative_seen_next;
  logic        error_seen, error_seen_next;
  logic [2:0]  null_match, null_match_next;

  logic        out_free;
  logic        fire;
  logic [7:0]  b;
  logic        last;
  result_t     res_next;
  result_t     fin;
  logic [3:0]  digit;
  logic [63:0] acc_sum;
  logic [4:0]  count_sat;
  logic [4:0]  digit_lim;
  logic        is_minus;
  logic        non_digit;
  logic [63:0] len_lim;

  assign b    = in_item.data_byte;
  assign last = in_item.line_end;

  // Bytes that end no line never wait for the output side
  assign out_free   = !out_valid || out_ready;
  assign core_ready = !last || out_free;
  assign fire       = in_valid && core_ready;

  // Digit step: acc * 10 + d as shift-add
  assign digit     = 4'(held_byte - CH_ZERO);
  assign acc_sum   = (accumulator << 3) + (accumulator << 1) + {60'd0, digit};
  assign count_sat = (digit_count == DIGIT_COUNT_MAX) ? digit_count : digit_count + 5'd1;
  assign digit_lim = (mode == KIND_BULK) ? BULK_MAX_DIGITS : ARRAY_MAX_DIGITS;
  assign is_minus  = (mode == KIND_INT) && (held_byte == CH_MINUS) &&
                     (digit_count == 5'd0) && !negative_seen;
  assign non_digit = (held_byte < CH_ZERO) || (held_byte > CH_NINE);
  assign len_lim   = (mode == KIND_BULK) ? {{(64-LIMIT_W){1'b0}}, bulk_limit} : ARRAY_LEN_MAX;

  // Result of a line that ends after at least one body position
  always_comb begin
    fin.number_value = 64'd0;
    fin.line_kind    = mode;
    fin.parse_status = ST_OK;
    case (mode)
      KIND_INT: begin
        if (error_seen || digit_count == 5'd0) begin
          fin.parse_status = ST_BAD;
        end else if (accumulator == TWO_POW_63) begin
          if (negative_seen) begin
            fin.number_value = TWO_POW_63;
          end else begin
            fin.parse_status = ST_BAD;
          end
        end else begin
          fin.number_value = negative_seen ? (64'd0 - accumulator) : accumulator;
        end
      end
      KIND_BULK, KIND_ARRAY: begin
        if (null_match == NPM_TAIL && b == CH_LF) begin
          fin.parse_status = ST_NULL;
        end else if (error_seen || digit_count == 5'd0) begin
          fin.parse_status = ST_BAD;
        end else if (accumulator > len_lim) begin
          fin.parse_status = ST_BAD;
        end else begin
          fin.number_value = accumulator;
        end
      end
      default: begin
        fin.parse_status = ST_OK;
      end
    endcase
  end

  // Next state for one accepted byte
  always_comb begin
    at_line_start_next = at_line_start;
    mode_next          = mode;
    held_byte_next     = held_byte;
    held_valid_next    = held_valid;
    accumulator_next   = accumulator;
    digit_count_next   = digit_count;
    negative_seen_next = negative_seen;
    error_seen_next    = error_seen;
    null_match_next    = null_match;
    res_next           = fin;
    if (fire) begin
      if (at_line_start) begin
        // Type byte: start a fresh line
        mode_next          = kind_of(b);
        held_byte_next     = 8'd0;
        held_valid_next    = 1'b0;
        accumulator_next   = 64'd0;
        digit_count_next   = 5'd0;
        negative_seen_next = 1'b0;
        error_seen_next    = 1'b0;
        null_match_next    = (kind_of(b) == KIND_BULK || kind_of(b) == KIND_ARRAY) ?
                             NPM_START : NPM_BROKEN;
        at_line_start_next = last;
        res_next.number_value = 64'd0;
        res_next.line_kind    = kind_of(b);
        res_next.parse_status = (kind_of(b) == KIND_OTHER) ? ST_OK : ST_BAD;
      end else if (last) begin
        at_line_start_next = 1'b1;
      end else begin
        // Consume the held body byte; the newest byte waits since it may be CR
        if (held_valid && mode != KIND_OTHER && !error_seen) begin
          if (is_minus) begin
            negative_seen_next = 1'b1;
          end else if (non_digit) begin
            error_seen_next = 1'b1;
          end else begin
            digit_count_next = count_sat;
            if (mode == KIND_INT) begin
              if (accumulator > PRE_MUL_MAX || acc_sum > TWO_POW_63) begin
                error_seen_next = 1'b1;
              end else begin
                accumulator_next = acc_sum;
              end
            end else if (count_sat > digit_lim) begin
              error_seen_next = 1'b1;
            end else begin
              accumulator_next = acc_sum;
            end
          end
        end
        // Track the null pattern on the newest byte
        if (null_match < NPM_END && b == null_tail(null_match)) begin
          null_match_next = null_match + 3'd1;
        end else begin
          null_match_next = NPM_BROKEN;
        end
        held_byte_next  = b;
        held_valid_next = 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      mode          <= KIND_INT;
      held_byte     <= 8'd0;
      held_valid    <= 1'b0;
      accumulator   <= 64'd0;
      digit_count   <= 5'd0;
      negative_seen <= 1'b0;
      error_seen    <= 1'b0;
      null_match    <= 3'd0;
    end else begin
      at_line_start <= at_line_start_next;
      mode          <= mode_next;
      held_byte     <= held_byte_next;
      held_valid    <= held_valid_next;
      accumulator   <= accumulator_next;
      digit_count   <= digit_count_next;
      negative_seen <= negative_seen_next;
      error_seen    <= error_seen_next;
      null_match    <= null_match_next;
    end
  end

  // Result register: load on a line end, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && last) begin
      result <= res_next;
    end
  end

  // A result appears only after a line end was taken
  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && last))
    else $error("result without line end");

  // A line end always returns the parser to the line start
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    fire && last |=> at_line_start)
    else $error("line end did not restart line");

  // Null results are length lines with a zero value
  a_null_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.parse_status == ST_NULL |->
      result.number_value == 64'd0 &&
      (result.line_kind == KIND_BULK || result.line_kind == KIND_ARRAY))
    else $error("bad null result");

  // Malformed results carry a zero value
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.parse_status == ST_BAD |-> result.number_value == 64'd0)
    else $error("malformed result with nonzero value");

endmodule

### src/resp_number_line_parser_unit.sv
// Top level of the RESP number line parser with its configuration port.
//
// Usage: feed the bytes of a RESP header line on the s_ channel, type byte first,
// with s_tlast high on the final LF. One result per line leaves on the m_ channel:
// m_tdata carries the parsed 64-bit value, m_tuser the line kind and status.
// The user must write the bulk length limit over the APB-style port at byte address 0
// only while no line is in flight; the block itself does not enforce this.
// Throughput: one byte per cycle, back to back, save that a line's final byte waits
// while the result register is full. The multiply-by-ten-and-add on the 64-bit
// accumulator in the core is combinational. The LF transfer is registered in the
// input register, and its result then in the result register.
// Reset (rst, synchronous) empties both registers, returns to a line start and
// restores the bulk limit to 536870912.
// When the receiver stalls, body bytes keep flowing; only a line's final byte
// waits in the input register until the result register frees up, and s_tready
// then drops.
module resp_number_line_parser_unit
  import rnlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Byte stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [7:0] data_byte
  input  logic              s_tlast,   // line_end
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [63:0]       m_tdata,   // [63:0] number_value (signed)
  output logic [3:0]        m_tuser,   // [1:0] line_kind, [3:2] parse_status
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [LIMIT_W-1:0] bulk_limit;
  item_t              s_item;
  item_t              st_item;
  logic               st_valid;
  logic               core_ready;
  result_t            result;
  logic               reg_sel;

  // Register decode by word address
  assign pready  = 1'b1;
  assign reg_sel = (paddr[ADDR_W-1] == REG_BULK_LIMIT);
  assign prdata  = reg_sel ? {{(32-LIMIT_W){1'b0}}, bulk_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bulk_limit <= BULK_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      bulk_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign s_item.data_byte = s_tdata;
  assign s_item.line_end  = s_tlast;

  rnlp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .valid      (st_valid),
    .item       (st_item),
    .core_ready (core_ready)
  );

  rnlp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (st_valid),
    .in_item    (st_item),
    .core_ready (core_ready),
    .bulk_limit (bulk_limit),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .result     (result)
  );

  assign m_tdata = result.number_value;
  assign m_tuser = {result.parse_status, result.line_kind};

endmodule

### dv/testbench.sv
// Self-checking testbench for the RESP number line parser unit.
module testbench;
  import rnlp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;  // [7:0] data_byte
  logic s_tlast = 1'b0;         // line_end
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;         // [63:0] number_value (signed)
  logic [3:0] m_tuser;          // [1:0] line_kind, [3:2] parse_status
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  resp_number_line_parser_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Pending input bytes and expected parsed lines
  item_t byte_stream[$];
  result_t expected_lines[$];
  logic [7:0] line_buf[$];
  int queued_bytes = 0;
  int fail_count = 0;

  // Parser state mirrored by the predictor
  logic [LIMIT_W-1:0] bulk_limit_now = BULK_LIMIT_RESET;
  bit at_start = 1'b1;
  kind_t line_mode = KIND_INT;
  logic [7:0] held = 8'h00;
  bit held_ok = 1'b0;
  logic [63:0] acc = '0;
  logic [4:0] ndig = '0;
  bit neg = 1'b0;
  bit err = 1'b0;
  logic [2:0] npm = '0;

  // Fold one body byte into the number being parsed
  function automatic void absorb_body(input logic [7:0] b);
    logic [63:0] d;
    if (line_mode == KIND_OTHER || err) return;
    if (line_mode == KIND_INT && b == CH_MINUS && ndig == 0 && !neg) begin
      neg = 1'b1;
      return;
    end
    if (b < CH_ZERO || b > CH_NINE) begin
      err = 1'b1;
      return;
    end
    d = 64'(b - CH_ZERO);
    if (ndig != DIGIT_COUNT_MAX) ndig++;
    if (line_mode == KIND_INT) begin
      if (acc > TWO_POW_63 / 64'd10) begin
        err = 1'b1;
        return;
      end
      acc = acc * 64'd10;
      if (acc > TWO_POW_63 - d) begin
        err = 1'b1;
        return;
      end
      acc = acc + d;
    end else begin
      if (ndig > ((line_mode == KIND_BULK) ? BULK_MAX_DIGITS : ARRAY_MAX_DIGITS))
        err = 1'b1;
      else
        acc = acc * 64'd10 + d;
    end
  endfunction

  // Advance the minus-one match over a non-final byte
  function automatic void follow_null(input logic [7:0] b);
    logic [7:0] want;
    case (npm)
      3'd1:    want = CH_MINUS;
      3'd2:    want = CH_ONE;
      3'd3:    want = CH_CR;
      3'd4:    want = CH_LF;
      default: want = 8'h00;
    endcase
    if (npm < NPM_END && b == want) npm = npm + 3'd1;
    else npm = NPM_BROKEN;
  endfunction

  // Build the result of the line that ends on last_byte
  function automatic result_t close_line(input logic [7:0] last_byte, input bit on_type);
    result_t r;
    r.number_value = '0;
    r.line_kind = line_mode;
    r.parse_status = ST_OK;
    case (line_mode)
      KIND_INT: begin
        if (err || ndig == 0) r.parse_status = ST_BAD;
        else if (acc == TWO_POW_63) begin
          if (neg) r.number_value = TWO_POW_63;
          else r.parse_status = ST_BAD;
        end else r.number_value = neg ? 64'd0 - acc : acc;
      end
      KIND_BULK, KIND_ARRAY: begin
        if (!on_type && npm == NPM_TAIL && last_byte == CH_LF) r.parse_status = ST_NULL;
        else if (err || ndig == 0) r.parse_status = ST_BAD;
        else if (acc > ((line_mode == KIND_BULK) ? 64'(bulk_limit_now) : ARRAY_LEN_MAX))
          r.parse_status = ST_BAD;
        else r.number_value = acc;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Step the parser by one byte; returns 1 when a line result comes out
  function automatic bit parse_byte(input logic [7:0] b, input logic line_end,
                                    output result_t r);
    r = '0;
    if (at_start) begin
      held = 8'h00;
      held_ok = 1'b0;
      acc = '0;
      ndig = '0;
      neg = 1'b0;
      err = 1'b0;
      case (b)
        CH_COLON:  line_mode = KIND_INT;
        CH_DOLLAR: line_mode = KIND_BULK;
        CH_STAR:   line_mode = KIND_ARRAY;
        default:   line_mode = KIND_OTHER;
      endcase
      npm = (line_mode == KIND_BULK || line_mode == KIND_ARRAY) ? NPM_START : NPM_BROKEN;
      at_start = 1'b0;
      if (line_end) begin
        r = close_line(b, 1'b1);
        at_start = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (line_end) begin
      r = close_line(b, 1'b0);
      at_start = 1'b1;
      return 1'b1;
    end
    if (held_ok) absorb_body(held);
    follow_null(b);
    held = b;
    held_ok = 1'b1;
    return 1'b0;
  endfunction

  // Line assembly helpers
  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic add_num(input logic [63:0] v);
    add_str($sformatf("%0d", v));
  endtask

  task automatic add_digits(input int n);
    repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic add_crlf();
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endtask

  task automatic flush_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      byte_stream.push_back('{data_byte: line_buf[i], line_end: (i == line_buf.size() - 1)});
      queued_bytes++;
    end
    line_buf.delete();
  endtask

  task automatic crlf_line(input string s);
    add_str(s);
    add_crlf();
    flush_line();
  endtask

  // Length line near a limit, in range, a null, or a raw digit run
  task automatic add_length(input logic [63:0] lim, input int max_digits);
    logic [63:0] v;
    case ($urandom_range(0, 3))
      0: add_str("-1");
      1: begin
        v = lim + 64'($urandom_range(0, 4)) - 64'd2;
        if (v[63]) v = '0;
        add_num(v);
      end
      2: add_num({$urandom, $urandom} % (lim + 64'd1));
      default: add_digits($urandom_range(1, max_digits + 2));
    endcase
  endtask

  // One random line: mostly well formed, some corrupted, some noise
  task automatic make_random_line();
    int sel;
    logic [7:0] t;
    bit corrupt;
    sel = $urandom_range(0, 99);
    corrupt = ($urandom_range(0, 9) == 0);
    if (sel < 30) begin
      line_buf.push_back(CH_COLON);
      if ($urandom_range(0, 1)) line_buf.push_back(CH_MINUS);
      case ($urandom_range(0, 2))
        0: add_num({$urandom, $urandom} >> $urandom_range(0, 63));
        1: add_num(TWO_POW_63 + 64'($urandom_range(0, 6)) - 64'd3);
        default: add_digits($urandom_range(1, 22));
      endcase
      add_crlf();
    end else if (sel < 50) begin
      line_buf.push_back(CH_DOLLAR);
      add_length(64'(bulk_limit_now), BULK_MAX_DIGITS);
      add_crlf();
    end else if (sel < 70) begin
      line_buf.push_back(CH_STAR);
      add_length(ARRAY_LEN_MAX, ARRAY_MAX_DIGITS);
      add_crlf();
    end else if (sel < 80) begin
      t = 8'($urandom_range(0, 255));
      while (t == CH_COLON || t == CH_DOLLAR || t == CH_STAR) t = 8'($urandom_range(0, 255));
      line_buf.push_back(t);
      repeat ($urandom_range(0, 8)) line_buf.push_back(8'($urandom_range(32, 126)));
      add_crlf();
    end else begin
      case ($urandom_range(0, 3))
        0: line_buf.push_back(CH_COLON);
        1: line_buf.push_back(CH_DOLLAR);
        2: line_buf.push_back(CH_STAR);
        default: line_buf.push_back(8'($urandom_range(0, 255)));
      endcase
      repeat ($urandom_range(0, 10)) line_buf.push_back(8'($urandom_range(0, 255)));
    end
    if (corrupt) line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
    flush_line();
  endtask

  // Sender: bursts of random length with random gaps, or with no gaps when steady
  bit byte_taken = 1'b0;
  bit steady_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !byte_taken) begin
      // hold the offered byte until it is taken
    end else if (gap_left != 0) begin
      gap_left--;
      s_tvalid <= 1'b0;
    end else if (byte_stream.size() == 0) begin
      s_tvalid <= 1'b0;
    end else begin
      s_tvalid <= 1'b1;
      s_tdata <= byte_stream[0].data_byte;
      s_tlast <= byte_stream[0].line_end;
      if (burst_left != 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap_left = steady_sender ? 0 : $urandom_range(0, 8);
      end
    end
  end

  // Receiver: stall on a rotating pattern, or hold off on request
  bit stall_request = 1'b0;
  int hold_cycles = 0;
  int pattern_age = 0;
  logic [15:0] stall_pattern = '1;
  logic [3:0] pattern_pos = '0;

  always @(negedge clk) begin
    if (stall_request) begin
      hold_cycles = HOLD_OFF_CYCLES;
      stall_request = 1'b0;
    end
    if (hold_cycles != 0) begin
      hold_cycles--;
      m_tready <= 1'b0;
    end else begin
      if (pattern_age == 0) begin
        pattern_age = $urandom_range(16, 96);
        stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
      pattern_age--;
      m_tready <= stall_pattern[pattern_pos];
      pattern_pos = pattern_pos + 4'd1;
    end
  end

  // Predict on every accepted input transfer
  result_t predicted;

  always @(posedge clk) begin
    byte_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      byte_taken = 1'b1;
      if (parse_byte(s_tdata, s_tlast, predicted)) expected_lines.push_back(predicted);
      void'(byte_stream.pop_front());
    end
  end

  // Check every result transfer against the oldest expected line
  result_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_lines.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: value %0d kind %0d status %0d",
                   $signed(m_tdata), m_tuser[1:0], m_tuser[3:2]);
      end else begin
        want = expected_lines.pop_front();
        if (m_tdata !== want.number_value || m_tuser[1:0] !== want.line_kind ||
            m_tuser[3:2] !== want.parse_status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected value %0d kind %0d status %0d, got value %0d kind %0d status %0d",
                     $signed(want.number_value), want.line_kind, want.parse_status,
                     $signed(m_tdata), m_tuser[1:0], m_tuser[3:2]);
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("** resp_number_line_parser_unit: FAILED **");
      $finish;
    end
  end

  // Write the bulk length limit over the config port
  task automatic write_bulk_limit(input logic [31:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'(4 * REG_BULK_LIMIT);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    bulk_limit_now = v[LIMIT_W-1:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Wait until every byte is taken and every result has arrived
  task automatic settle();
    @(negedge clk);
    while (byte_stream.size() != 0 || expected_lines.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic random_phase(input int n_bytes);
    int stop_at;
    stop_at = queued_bytes + n_bytes;
    while (queued_bytes < stop_at) make_random_line();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lines at the reset limit
    crlf_line(":0");
    crlf_line(":-0");
    crlf_line(":9223372036854775807");
    crlf_line(":-9223372036854775808");
    crlf_line(":9223372036854775808");
    crlf_line(":-9223372036854775809");
    crlf_line(":99999999999999999999");
    crlf_line(":-");
    crlf_line(":");
    crlf_line(":--5");
    crlf_line(":12a");
    line_buf.push_back(CH_COLON);
    flush_line();
    line_buf.push_back(CH_COLON);
    line_buf.push_back(CH_LF);
    flush_line();
    crlf_line("$-1");
    crlf_line("*-1");
    add_str("$-1");
    line_buf.push_back(CH_CR);
    line_buf.push_back(CH_CR);
    flush_line();
    crlf_line("$-2");
    crlf_line("$0");
    crlf_line("$536870912");
    crlf_line("$536870913");
    crlf_line("$0000000001");
    crlf_line("*4294967295");
    crlf_line("*4294967296");
    crlf_line("*00000000001");
    crlf_line("+OK");
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h00);
    add_crlf();
    flush_line();
    settle();

    // Limit at zero, receiver held off while the sender keeps pushing
    write_bulk_limit(32'd0);
    steady_sender = 1'b1;
    stall_request = 1'b1;
    random_phase(380);
    settle();

    // Largest nine-digit limit
    write_bulk_limit(32'd999999999);
    steady_sender = 1'b0;
    crlf_line("$999999999");
    random_phase(360);
    settle();

    // Random limit, bursty sender
    write_bulk_limit($urandom_range(0, 999999999));
    random_phase(360);
    settle();

    // Small limit, back-to-back bytes
    write_bulk_limit($urandom_range(1, 999));
    steady_sender = 1'b1;
    random_phase(360);
    settle();

    repeat (12) @(negedge clk);
    if (fail_count == 0 && expected_lines.size() == 0)
      $display("** resp_number_line_parser_unit: PASSED **");
    else
      $display("** resp_number_line_parser_unit: FAILED **");
    $finish;
  end

endmodule
